/* src/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants for the scalar field encoder
// Type codes, wire types, the work descriptor and the varint length function.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

    // Scalar type codes carried on the input tuser.
    localparam logic [3:0] FN_DOUBLE   = 4'd0;
    localparam logic [3:0] FN_FLOAT    = 4'd1;
    localparam logic [3:0] FN_INT32    = 4'd2;
    localparam logic [3:0] FN_SINT32   = 4'd3;
    localparam logic [3:0] FN_UINT32   = 4'd4;
    localparam logic [3:0] FN_INT64    = 4'd5;
    localparam logic [3:0] FN_SINT64   = 4'd6;
    localparam logic [3:0] FN_UINT64   = 4'd7;
    localparam logic [3:0] FN_FIXED32  = 4'd8;
    localparam logic [3:0] FN_SFIXED32 = 4'd9;
    localparam logic [3:0] FN_FIXED64  = 4'd10;
    localparam logic [3:0] FN_SFIXED64 = 4'd11;
    localparam logic [3:0] FN_BOOL     = 4'd12;
    localparam logic [3:0] FN_ENUM     = 4'd13;

    // Wire types placed in the low three bits of the tag.
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_I32    = 3'd5;

    localparam int unsigned FIELD_NUM_W = 29;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned TAG_W       = FIELD_NUM_W + 3;

    // One classified field, ready for serialization.
    typedef struct packed {
        logic [TAG_W-1:0]   tag;       // (number << 3) | wire type
        logic [2:0]         tag_len;   // varint bytes of the tag, 1 to 5
        logic [VALUE_W-1:0] payload;   // value after sign extension or zigzag
        logic [3:0]         pay_len;   // value bytes, 1 to 10
        logic               fixed;     // little-endian bytes instead of varint
    } t_desc;

    // Queue status seen by the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Number of base-128 groups needed for a value; zero still takes one byte.
    function automatic logic [3:0] varint_len(input logic [VALUE_W-1:0] v);
        logic [3:0] len;
        len = 4'd1;
        for (int k = 1; k < 10; k++) begin
            if ((v >> (7 * k)) != '0) begin
                len = 4'(k + 1);
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

/* src/pse_front.sv */
// ----------------------------------------------------------------------------
// pse_front: input side of the scalar field encoder
// Takes field transfers, builds the tag and payload and sizes both parts.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_front
    import pse_pkg::*;
(
    input  wire logic                   i_valid,
    output      logic                   o_ready,
    input  wire logic [3:0]             i_func,
    input  wire logic [FIELD_NUM_W-1:0] i_field_num,
    input  wire logic [VALUE_W-1:0]     i_value_bits,
    input  wire logic                   i_q_ready,
    output      logic                   o_push,
    output      t_desc                  o_desc
);

    logic               known;
    logic [2:0]         wt;
    logic               fixed;
    logic [VALUE_W-1:0] pay;
    logic [31:0]        lo;
    logic [TAG_W-1:0]   tag;
    logic [3:0]         tag_len_full;

    assign lo = i_value_bits[31:0];

    always_comb begin
        known = 1'b1;
        wt    = WT_VARINT;
        fixed = 1'b0;
        pay   = i_value_bits;
        unique case (i_func) inside
            FN_DOUBLE, FN_FIXED64, FN_SFIXED64: begin
                wt    = WT_I64;
                fixed = 1'b1;
            end
            FN_FLOAT, FN_FIXED32, FN_SFIXED32: begin
                wt    = WT_I32;
                fixed = 1'b1;
                pay   = {32'd0, lo};
            end
            FN_INT32, FN_ENUM: begin
                pay = {{32{lo[31]}}, lo};
            end
            FN_SINT32: begin
                pay = {32'd0, {lo[30:0], 1'b0} ^ {32{lo[31]}}};
            end
            FN_UINT32: begin
                pay = {32'd0, lo};
            end
            FN_INT64, FN_UINT64: begin
                pay = i_value_bits;
            end
            FN_SINT64: begin
                pay = {i_value_bits[62:0], 1'b0} ^ {VALUE_W{i_value_bits[63]}};
            end
            FN_BOOL: begin
                pay = {63'd0, (i_value_bits != '0)};
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign tag          = {i_field_num, wt};
    assign tag_len_full = varint_len({{(VALUE_W-TAG_W){1'b0}}, tag});

    assign o_desc.tag     = tag;
    assign o_desc.tag_len = tag_len_full[2:0];
    assign o_desc.payload = pay;
    assign o_desc.pay_len = fixed ? ((wt == WT_I64) ? 4'd8 : 4'd4) : varint_len(pay);
    assign o_desc.fixed   = fixed;

    // Unknown type codes are taken and dropped without a queue entry.
    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready && known;

endmodule

`default_nettype wire

/* src/pse_queue.sv */
// ----------------------------------------------------------------------------
// pse_queue: descriptor queue between classifier and serializer
// A small register FIFO with first-word fall-through on the read side.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_queue
    import pse_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    input  wire logic  i_pop,
    output      t_desc o_desc,
    output      t_qstat o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    assign o_desc       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

/* src/pse_back.sv */
// ----------------------------------------------------------------------------
// pse_back: wire byte serializer
// Shifts out tag and value bytes from the current descriptor into an
// output register, one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_back
    import pse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_desc      i_desc,
    input  wire t_qstat     i_qstat,
    output      logic       o_pop,
    output      logic       o_valid,
    input  wire logic       i_ready,
    output      logic [7:0] o_byte,
    output      logic       o_last
);

    logic               r_act;
    logic [TAG_W-1:0]   r_tag;
    logic [2:0]         r_tcnt;
    logic [VALUE_W-1:0] r_pay;
    logic [3:0]         r_pcnt;
    logic               r_fix;
    logic               r_ovalid;
    logic [7:0]         r_obyte;
    logic               r_olast;

    logic       step;
    logic [7:0] cur_byte;
    logic       cur_last;

    // A byte moves into the output register whenever that register is free
    // or being emptied in the same cycle.
    assign step = r_act && (!r_ovalid || i_ready);

    always_comb begin
        cur_last = 1'b0;
        if (r_tcnt != '0) begin
            cur_byte = {(r_tcnt != 3'd1), r_tag[6:0]};
        end else if (r_fix) begin
            cur_byte = r_pay[7:0];
            cur_last = (r_pcnt == 4'd1);
        end else begin
            cur_byte = {(r_pcnt != 4'd1), r_pay[6:0]};
            cur_last = (r_pcnt == 4'd1);
        end
    end

    // The next descriptor loads on the cycle the last byte leaves, so queued
    // fields follow each other without a gap.
    assign o_pop = !i_qstat.empty && (!r_act || (step && cur_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (step && cur_last) begin
                r_act <= 1'b0;
            end
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tag  <= i_desc.tag;
            r_tcnt <= i_desc.tag_len;
            r_pay  <= i_desc.payload;
            r_pcnt <= i_desc.pay_len;
            r_fix  <= i_desc.fixed;
        end else if (step) begin
            if (r_tcnt != '0) begin
                r_tag  <= r_tag >> 7;
                r_tcnt <= r_tcnt - 1'b1;
            end else begin
                r_pay  <= r_fix ? (r_pay >> 8) : (r_pay >> 7);
                r_pcnt <= r_pcnt - 1'b1;
            end
        end
        if (step) begin
            r_obyte <= cur_byte;
            r_olast <= cur_last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

/* src/protobuf_scalar_field_encoder_top.sv */
// ----------------------------------------------------------------------------
// protobuf_scalar_field_encoder_top: scalar protobuf field to wire bytes
// Encodes one field per input transfer as tag varint plus value bytes.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one scalar field per transfer: the type code on
// tuser, the field number and the 64 raw value bits on tdata. The master
// stream gives one wire byte per transfer, with tlast on the final byte of
// the field. The tag goes out first as a varint, then the value as 4 or 8
// little-endian bytes or as a varint (zigzag for sint types, sign extension
// to 10 bytes for negative int32 and enum).
// A field gives 2 to 15 bytes on the output; the one-byte output channel
// sets the sustained rate. Bytes of consecutive fields follow each other
// without a gap while the next field is already queued.
// The classified field enters the queue at the accepting edge; when the block
// is empty, the serializer then loads it from the queue head and registers
// its first byte in the output register.
// Fields with type codes 14 or 15 are accepted and produce no bytes.
// s_axis_tready falls only when the descriptor queue is full; a stalled
// output holds its byte while the input side keeps filling the queue.
// Reset empties the queue, drops any field in progress and clears tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_scalar_field_encoder_top
    import pse_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2  // descriptor entries, at least 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // [28:0] field number, [92:29] value_bits, zero pad
    input  wire logic [3:0]  s_axis_tuser,   // [3:0] func
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output      logic        m_axis_tlast    // last_byte
);

    logic   q_push;
    logic   q_pop;
    logic   q_ready;
    t_desc  push_desc;
    t_desc  head_desc;
    t_qstat q_stat;

    assign q_ready = !q_stat.full;

    // Front: classify the field and size the tag and value.
    pse_front u_front (
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_func         (s_axis_tuser),
        .i_field_num    (s_axis_tdata[FIELD_NUM_W-1:0]),
        .i_value_bits   (s_axis_tdata[FIELD_NUM_W+VALUE_W-1:FIELD_NUM_W]),
        .i_q_ready      (q_ready),
        .o_push         (q_push),
        .o_desc         (push_desc)
    );

    // Queue: lets input and output stall independently.
    pse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .i_pop   (q_pop),
        .o_desc  (head_desc),
        .o_stat  (q_stat)
    );

    // Back: one wire byte per output transfer.
    pse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (head_desc),
        .i_qstat (q_stat),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    // The queue is never written while full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("descriptor pushed into a full queue");

    // The serializer never takes a descriptor from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("descriptor popped from an empty queue");

    // Full and empty exclude each other.
    a_stat_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

endmodule

`default_nettype wire
